// File: rtl/oaie_pkg.sv
`timescale 1ns / 1ps
// Package for the ordered array with insert and erase.
// Holds operation, status and cell action codes, the request and response
// word types and the command broadcast to the cell row. No dependencies.
package oaie_pkg;

   // Defaults and fixed widths
   localparam int CAPACITY_DEF   = 128;
   localparam int WORD_WIDTH_DEF = 32;
   localparam int POS_W          = 8;
   localparam int VALUE_W        = 32;
   localparam int COUNT_W        = 8;
   // wide enough for a count of up to 1024 entries
   localparam int CNT_MAX_W      = 11;
   // widest supported stored word
   localparam int WORD_MAX_W     = 64;
   // cells per first-level read group
   localparam int GROUP_SIZE     = 16;

   typedef enum logic [2:0] {
      FN_GET        = 3'd0,
      FN_SET        = 3'd1,
      FN_PUSH_BACK  = 3'd2,
      FN_POP_BACK   = 3'd3,
      FN_PUSH_FRONT = 3'd4,
      FN_POP_FRONT  = 3'd5,
      FN_INSERT     = 3'd6,
      FN_ERASE      = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // What each cell does this cycle, qualified by its own index
   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_WRITE  = 2'd1,
      ACT_INSERT = 2'd2,
      ACT_ERASE  = 2'd3
   } act_type;

   typedef struct packed {
      func_type             func;
      logic [POS_W-1:0]     position;
      logic [VALUE_W-1:0]   value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]   read_value;
      status_type           status;
      logic [COUNT_W-1:0]   count;
      logic [COUNT_W-1:0]   free_space;
      logic                 is_empty;
      logic                 is_full;
   } rsp_type;

   // Broadcast to every cell
   typedef struct packed {
      act_type                 act;
      logic [CNT_MAX_W-1:0]    pos;
      logic [WORD_MAX_W-1:0]   word;
   } cell_cmd_type;

   // Per-operation outcome carried down the result pipeline
   typedef struct packed {
      logic                    valid;
      status_type              status;
      logic                    rd_en;
      logic [CNT_MAX_W-1:0]    count;
   } op_info_type;

endpackage

// File: rtl/oaie_cell.sv
`timescale 1ns / 1ps
// One storage cell of the ordered array row.
// Depends on oaie_pkg for the command broadcast.
module oaie_cell #(
   parameter int WORD_WIDTH = oaie_pkg::WORD_WIDTH_DEF,
   parameter int INDEX      = 0
) (
   input  logic                    clock,
   input  oaie_pkg::cell_cmd_type  cmd,
   input  logic [WORD_WIDTH-1:0]   lower_word,
   input  logic [WORD_WIDTH-1:0]   upper_word,
   output logic [WORD_WIDTH-1:0]   word,
   output logic [WORD_WIDTH-1:0]   tap
);
   import oaie_pkg::*;

   logic [WORD_WIDTH-1:0] word_ff;
   logic [WORD_WIDTH-1:0] word_in;
   logic                  hit;
   logic                  above;

   assign hit   = cmd.pos == CNT_MAX_W'(INDEX);
   assign above = CNT_MAX_W'(INDEX) > cmd.pos;

   // hold, load, or take a neighbor's word
   always_comb begin
      word_in = word_ff;
      case (cmd.act)
         ACT_WRITE: begin
            if (hit) word_in = cmd.word[WORD_WIDTH-1:0];
         end
         ACT_INSERT: begin
            if (hit) word_in = cmd.word[WORD_WIDTH-1:0];
            else if (above) word_in = lower_word;
         end
         ACT_ERASE: begin
            if (hit || above) word_in = upper_word;
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   // read tap: only the addressed cell drives its word onto the OR tree
   assign tap  = hit ? word_ff : '0;

endmodule

// File: rtl/oaie_ctrl.sv
`timescale 1ns / 1ps
// Operation decode and fill count for the ordered array.
// Depends on oaie_pkg; drives the cell row command and the outcome record.
module oaie_ctrl #(
   parameter int CAPACITY = oaie_pkg::CAPACITY_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  oaie_pkg::req_type       req,
   output oaie_pkg::cell_cmd_type  cmd,
   output oaie_pkg::op_info_type   info
);
   import oaie_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]     fill_count_ff;
   logic [CNT_W-1:0]     fill_count_in;
   logic [CNT_W-1:0]     cnt_next;
   logic [CNT_MAX_W-1:0] cnt_w;
   logic [CNT_MAX_W-1:0] pos_w;
   logic                 full;
   logic                 empty;
   status_type           st;
   act_type              act;
   logic [CNT_MAX_W-1:0] tpos;
   logic                 rd_en;

   assign cnt_w = CNT_MAX_W'(fill_count_ff);
   assign pos_w = CNT_MAX_W'(req.position);
   assign full  = fill_count_ff == CNT_W'(CAPACITY);
   assign empty = fill_count_ff == '0;

   // decode: status, cell action, target position and new count
   always_comb begin
      st       = ST_DONE;
      act      = ACT_NONE;
      tpos     = pos_w;
      cnt_next = fill_count_ff;
      rd_en    = 1'b0;
      case (req.func)
         FN_GET: begin
            if (pos_w >= cnt_w) st = ST_RANGE;
            else rd_en = 1'b1;
         end
         FN_SET: begin
            if (pos_w >= cnt_w) st = ST_RANGE;
            else act = ACT_WRITE;
         end
         FN_PUSH_BACK: begin
            tpos = cnt_w;
            if (full) st = ST_FULL;
            else begin
               act      = ACT_WRITE;
               cnt_next = fill_count_ff + CNT_W'(1);
            end
         end
         FN_POP_BACK: begin
            if (empty) st = ST_EMPTY;
            else cnt_next = fill_count_ff - CNT_W'(1);
         end
         FN_PUSH_FRONT: begin
            tpos = '0;
            if (full) st = ST_FULL;
            else begin
               act      = ACT_INSERT;
               cnt_next = fill_count_ff + CNT_W'(1);
            end
         end
         FN_POP_FRONT: begin
            tpos = '0;
            if (empty) st = ST_EMPTY;
            else begin
               act      = ACT_ERASE;
               cnt_next = fill_count_ff - CNT_W'(1);
            end
         end
         FN_INSERT: begin
            if (full) st = ST_FULL;
            else if (pos_w > cnt_w) st = ST_RANGE;
            else begin
               act      = ACT_INSERT;
               cnt_next = fill_count_ff + CNT_W'(1);
            end
         end
         FN_ERASE: begin
            if (empty) st = ST_EMPTY;
            else if (pos_w >= cnt_w) st = ST_RANGE;
            else begin
               act      = ACT_ERASE;
               cnt_next = fill_count_ff - CNT_W'(1);
            end
         end
         default: st = ST_DONE;
      endcase
   end

   // outputs: cells act only on an accepted word
   always_comb begin
      cmd.act       = accept ? act : ACT_NONE;
      cmd.pos       = tpos;
      cmd.word      = WORD_MAX_W'(req.value);
      info.valid    = accept;
      info.status   = st;
      info.rd_en    = rd_en;
      info.count    = CNT_MAX_W'(cnt_next);
      fill_count_in = accept ? cnt_next : fill_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
      end else begin
         fill_count_ff <= fill_count_in;
      end
   end

   // count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   // a rejected operation leaves the count alone
   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && st != ST_DONE) |=> fill_count_ff == $past(fill_count_ff))
      else $error("rejected operation changed the count");

   // the count moves by at most one per operation
   a_step_one: assert property (@(posedge clock) disable iff (reset)
      accept |=> (fill_count_ff == $past(fill_count_ff)
                  || fill_count_ff == $past(fill_count_ff) + CNT_W'(1)
                  || fill_count_ff == $past(fill_count_ff) - CNT_W'(1)))
      else $error("count moved by more than one");

endmodule

// File: rtl/ordered_array_insert_erase_top.sv
`timescale 1ns / 1ps
// Top level of the ordered array with shifting insert and erase.
// Depends on oaie_pkg, oaie_ctrl and oaie_cell.
//
// A new word is taken on every clock (busy stays low). Its response passes through
// the group and outcome registers, then the response register, and is held for one
// cycle on rsp_strobe; the receiver cannot stall it.
// Every operation, including an insert or erase that moves the whole list,
// finishes in the accepting cycle because each cell of the row picks hold,
// load, or a neighbor's word in parallel. The latency comes from the read path:
// a get gathers the addressed word through registered groups of 16 cells, then
// an OR across the groups feeds the response register.
module ordered_array_insert_erase_top #(
   parameter int CAPACITY   = oaie_pkg::CAPACITY_DEF,
   parameter int WORD_WIDTH = oaie_pkg::WORD_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  oaie_pkg::req_type  req_data,
   output logic               rsp_strobe,
   output oaie_pkg::rsp_type  rsp_data
);
   import oaie_pkg::*;

   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   logic                  accept;
   cell_cmd_type          cmd;
   op_info_type           info;
   logic [WORD_WIDTH-1:0] words [CAPACITY];
   logic [WORD_WIDTH-1:0] taps  [CAPACITY];
   logic [WORD_WIDTH-1:0] grp_in [NUM_GROUPS];
   logic [WORD_WIDTH-1:0] grp_ff [NUM_GROUPS];
   op_info_type           info_ff;
   logic [WORD_WIDTH-1:0] rd_all;
   logic [WORD_MAX_W-1:0] rd_wide;
   logic [CNT_MAX_W-1:0]  free_w;
   rsp_type               rsp_in;
   rsp_type               rsp_ff;
   logic                  rsp_strobe_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   oaie_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cmd    (cmd),
      .info   (info)
   );

   // row of cells, each linked to its lower and upper neighbor
   for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
      logic [WORD_WIDTH-1:0] lower_w;
      logic [WORD_WIDTH-1:0] upper_w;
      if (j == 0) begin : g_first
         assign lower_w = '0;
      end else begin : g_mid_lo
         assign lower_w = words[j-1];
      end
      if (j == CAPACITY - 1) begin : g_last
         assign upper_w = '0;
      end else begin : g_mid_hi
         assign upper_w = words[j+1];
      end
      oaie_cell #(
         .WORD_WIDTH (WORD_WIDTH),
         .INDEX      (j)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .lower_word (lower_w),
         .upper_word (upper_w),
         .word       (words[j]),
         .tap        (taps[j])
      );
   end

   // first read level: OR of the taps within each group
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < CAPACITY) begin
               grp_in[g] = grp_in[g] | taps[g * GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_ff[g] <= grp_in[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         info_ff.valid <= 1'b0;
      end else begin
         info_ff <= info;
      end
   end

   // second read level and response assembly
   always_comb begin
      rd_all = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         rd_all = rd_all | grp_ff[g];
      end
      rd_wide                   = '0;
      rd_wide[WORD_WIDTH-1:0]   = rd_all;
      free_w                    = CNT_MAX_W'(CAPACITY) - info_ff.count;
      rsp_in.read_value         = (info_ff.rd_en && info_ff.status == ST_DONE)
                                  ? rd_wide[VALUE_W-1:0] : '0;
      rsp_in.status             = info_ff.status;
      rsp_in.count              = info_ff.count[COUNT_W-1:0];
      rsp_in.free_space         = free_w[COUNT_W-1:0];
      rsp_in.is_empty           = info_ff.count == '0;
      rsp_in.is_full            = info_ff.count == CNT_MAX_W'(CAPACITY);
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= info_ff.valid;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // each accepted word gives its response strobe after the outcome and strobe registers
   a_rsp_timing: assert property (@(posedge clock)
      (!reset && !$past(reset) && !$past(reset, 2))
      |-> rsp_strobe_ff == $past(accept, 2))
      else $error("response strobe out of step with accepts");

   // count and free space always add to capacity
   a_rsp_space: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> COUNT_W'(rsp_ff.count + rsp_ff.free_space)
                        == COUNT_W'(CAPACITY))
      else $error("count and free space disagree");

endmodule

// File: tb/oaie_list_checker.sv
`timescale 1ns / 1ps
// Checker for the ordered array with insert and erase: keeps its own copy of
// the list, predicts each response word and compares it with the block.
// Depends on oaie_pkg for the request and response word types.
module oaie_list_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  oaie_pkg::req_type  req_data,
   input  logic               rsp_strobe,
   input  oaie_pkg::rsp_type  rsp_data,
   output int                 fill_level,
   output int                 pending_words,
   output int                 fail_count
);
   import oaie_pkg::*;

   localparam int LIST_CAP = CAPACITY_DEF;

   // shadow list and its fill
   logic [VALUE_W-1:0] list_cells [LIST_CAP];
   int                 list_fill;

   // responses predicted but not yet seen, oldest first
   rsp_type            expected_rsps [$];

   // apply one operation to the shadow list, return the response it gives
   function automatic rsp_type apply_list_op(req_type w);
      rsp_type r;
      int      p;
      int      j;
      bit      full;
      bit      empty;
      r      = '0;
      r.status = ST_DONE;
      p      = int'(w.position);
      full   = list_fill >= LIST_CAP;
      empty  = list_fill == 0;
      case (w.func)
         FN_GET: begin
            if (p >= list_fill) r.status = ST_RANGE;
            else r.read_value = list_cells[p];
         end
         FN_SET: begin
            if (p >= list_fill) r.status = ST_RANGE;
            else list_cells[p] = w.value;
         end
         FN_PUSH_BACK: begin
            if (full) r.status = ST_FULL;
            else begin
               list_cells[list_fill] = w.value;
               list_fill++;
            end
         end
         FN_POP_BACK: begin
            if (empty) r.status = ST_EMPTY;
            else list_fill--;
         end
         FN_PUSH_FRONT: begin
            if (full) r.status = ST_FULL;
            else begin
               for (j = list_fill; j > 0; j--) list_cells[j] = list_cells[j-1];
               list_cells[0] = w.value;
               list_fill++;
            end
         end
         FN_POP_FRONT: begin
            if (empty) r.status = ST_EMPTY;
            else begin
               for (j = 0; j + 1 < list_fill; j++) list_cells[j] = list_cells[j+1];
               list_fill--;
            end
         end
         FN_INSERT: begin
            if (full) r.status = ST_FULL;
            else if (p > list_fill) r.status = ST_RANGE;
            else begin
               for (j = list_fill; j > p; j--) list_cells[j] = list_cells[j-1];
               list_cells[p] = w.value;
               list_fill++;
            end
         end
         default: begin
            if (empty) r.status = ST_EMPTY;
            else if (p >= list_fill) r.status = ST_RANGE;
            else begin
               for (j = p; j + 1 < list_fill; j++) list_cells[j] = list_cells[j+1];
               list_fill--;
            end
         end
      endcase
      r.count      = COUNT_W'(list_fill);
      r.free_space = COUNT_W'(LIST_CAP - list_fill);
      r.is_empty   = list_fill == 0;
      r.is_full    = list_fill == LIST_CAP;
      return r;
   endfunction

   // count and print a mismatch
   task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, field, want, got);
   endtask

   // compare responses, then record the word accepted at this edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         list_fill = 0;
         expected_rsps.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               report_field("unexpected response", 32'h0, rsp_data.read_value);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.read_value !== want.read_value)
                  report_field("read_value", want.read_value, rsp_data.read_value);
               if (rsp_data.status !== want.status)
                  report_field("status", 32'(want.status), 32'(rsp_data.status));
               if (rsp_data.count !== want.count)
                  report_field("count", 32'(want.count), 32'(rsp_data.count));
               if (rsp_data.free_space !== want.free_space)
                  report_field("free_space", 32'(want.free_space),
                               32'(rsp_data.free_space));
               if (rsp_data.is_empty !== want.is_empty)
                  report_field("is_empty", 32'(want.is_empty), 32'(rsp_data.is_empty));
               if (rsp_data.is_full !== want.is_full)
                  report_field("is_full", 32'(want.is_full), 32'(rsp_data.is_full));
            end
         end
         if (start && !busy) expected_rsps.push_back(apply_list_op(req_data));
      end
      fill_level    <= list_fill;
      pending_words <= expected_rsps.size();
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the ordered array with insert and erase: resets the
// block, drives directed and phased random command words, gives the verdict.
// Depends on oaie_pkg, ordered_array_insert_erase_top and oaie_list_checker.
module tb_top;
   import oaie_pkg::*;

   typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} phase_type;

   logic     clock = 1'b0;
   logic     reset;
   logic     start;
   logic     busy;
   req_type  req_data;
   logic     rsp_strobe;
   rsp_type  rsp_data;
   int       fill_level;
   int       pending_words;
   int       fail_count;
   bit       burst_mode;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ordered_array_insert_erase_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   oaie_list_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .fill_level    (fill_level),
      .pending_words (pending_words),
      .fail_count    (fail_count)
   );

   function automatic req_type make_cmd(func_type f, int p, logic [31:0] v);
      req_type w;
      w.func     = f;
      w.position = POS_W'(p);
      w.value    = v;
      return w;
   endfunction

   // idle cycles after a word, with runs of back-to-back words
   function automatic int pick_gap();
      if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
      return burst_mode ? 0 : int'($urandom_range(0, 12));
   endfunction

   function automatic logic [31:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return 32'h0;
      if (roll < 10) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // position mostly inside the list, sometimes at or past its end
   function automatic int pick_position(int limit);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 6) return int'($urandom_range(0, 255));
      if (roll < 12) return fill_level + int'($urandom_range(0, 1));
      if (limit <= 0) return 0;
      return int'($urandom_range(0, limit - 1));
   endfunction

   // random command word biased by phase
   function automatic req_type random_cmd(phase_type ph);
      int       roll;
      func_type f;
      roll = $urandom_range(0, 99);
      if (ph == PH_MIXED) begin
         f = func_type'($urandom_range(0, 7));
      end else if (roll < 85) begin
         case ($urandom_range(0, 2))
            0: f = (ph == PH_GROW) ? FN_PUSH_BACK : FN_POP_BACK;
            1: f = (ph == PH_GROW) ? FN_PUSH_FRONT : FN_POP_FRONT;
            default: f = (ph == PH_GROW) ? FN_INSERT : FN_ERASE;
         endcase
      end else if (roll < 90) begin
         f = func_type'($urandom_range(0, 7));
      end else begin
         f = (roll < 95) ? FN_GET : FN_SET;
      end
      if (f == FN_INSERT) return make_cmd(f, pick_position(fill_level + 1), pick_value());
      return make_cmd(f, pick_position(fill_level), pick_value());
   endfunction

   // present one word, wait for acceptance, then idle if the gap is nonzero
   task automatic drive_word(req_type w, int gap);
      req_data <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stimulus and verdict
   initial begin
      req_type   directed [$];
      phase_type plan [5];
      int        plan_len [5];
      int        waited;
      burst_mode = 1'b0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty-list rejections, appends, middle inserts, range edges
      directed = '{
         make_cmd(FN_GET, 0, 32'h1),
         make_cmd(FN_SET, 0, 32'h2),
         make_cmd(FN_POP_BACK, 0, 32'h0),
         make_cmd(FN_POP_FRONT, 0, 32'h0),
         make_cmd(FN_ERASE, 0, 32'h0),
         make_cmd(FN_INSERT, 1, 32'h3),
         make_cmd(FN_INSERT, 0, 32'hFFFF_FFFF),
         make_cmd(FN_PUSH_BACK, 0, 32'h0),
         make_cmd(FN_PUSH_FRONT, 255, 32'h5A5A_A5A5),
         make_cmd(FN_INSERT, 3, 32'h8000_0001),
         make_cmd(FN_INSERT, 1, 32'h1234_5678),
         make_cmd(FN_GET, 0, 32'h0),
         make_cmd(FN_GET, 1, 32'h0),
         make_cmd(FN_GET, 4, 32'hFFFF_FFFF),
         make_cmd(FN_GET, 5, 32'h0),
         make_cmd(FN_GET, 255, 32'h0),
         make_cmd(FN_SET, 4, 32'hDEAD_BEEF),
         make_cmd(FN_SET, 5, 32'h0),
         make_cmd(FN_ERASE, 5, 32'h0),
         make_cmd(FN_ERASE, 2, 32'h0),
         make_cmd(FN_ERASE, 0, 32'h0),
         make_cmd(FN_INSERT, 255, 32'h7),
         make_cmd(FN_GET, 128, 32'h0),
         make_cmd(FN_POP_FRONT, 0, 32'h0),
         make_cmd(FN_POP_BACK, 0, 32'h0)
      };
      foreach (directed[i]) drive_word(directed[i], pick_gap());

      // fill to capacity, churn, drain to empty, refill, drain
      plan     = '{PH_GROW, PH_MIXED, PH_SHRINK, PH_GROW, PH_SHRINK};
      plan_len = '{200, 150, 200, 200, 150};
      foreach (plan[k]) begin
         for (int n = 0; n < plan_len[k]; n++) drive_word(random_cmd(plan[k]), pick_gap());
      end
      start <= 1'b0;

      waited = 0;
      while (pending_words != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_words != 0) begin
         $display("simulation failed");
      end else begin
         repeat (10) @(posedge clock);
         @(negedge clock);
         if (fail_count == 0) $display("simulation ok");
         else $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #500000;
      $display("simulation failed");
      $finish;
   end

endmodule
